[rtl/icwk_pkg.sv]
// ----------------------------------------------------------------------------
// icwk_pkg
// Shared types, register indexes and the dot length table of the CW keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package icwk_pkg;

  localparam int DOT_W  = 11;
  localparam int DASH_W = 13;
  localparam int TICK_W = 13;
  localparam int HANG_W = 12;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 12;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SPEED    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_WEIGHT   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MODE     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_REVERSED = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SPACING  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_HANG     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_BREAKIN  = 3'd6;

  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_IAMBIC_A = 2'd1;

  localparam logic [5:0]        SPEED_RST  = 6'd20;
  localparam logic [6:0]        WEIGHT_RST = 7'd50;
  localparam logic [1:0]        MODE_RST   = MODE_IAMBIC_A;
  localparam logic [HANG_W-1:0] HANG_RST   = 12'd300;
  localparam logic [DOT_W-1:0]  DOT_RST    = 11'd60;
  localparam logic [DASH_W-1:0] DASH_RST   = 13'd180;

  // settings the element sequencer needs
  typedef struct packed {
    logic [1:0]        keyer_mode;
    logic              keys_reversed;
    logic              letter_spacing;
    logic [HANG_W-1:0] hang_ticks;
    logic              breakin;
  } cfg_t;

  // one tick item, left_level in bit 0
  typedef struct packed {
    logic tx_on;
    logic right_hit;
    logic left_hit;
    logic right_level;
    logic left_level;
  } item_t;

  // 1200/wpm, speed saturated into 1..60
  localparam logic [DOT_W-1:0] DOT_TAB [0:63] = '{
    11'd1200, 11'd1200, 11'd600, 11'd400, 11'd300, 11'd240, 11'd200, 11'd171,
    11'd150,  11'd133,  11'd120, 11'd109, 11'd100, 11'd92,  11'd85,  11'd80,
    11'd75,   11'd70,   11'd66,  11'd63,  11'd60,  11'd57,  11'd54,  11'd52,
    11'd50,   11'd48,   11'd46,  11'd44,  11'd42,  11'd41,  11'd40,  11'd38,
    11'd37,   11'd36,   11'd35,  11'd34,  11'd33,  11'd32,  11'd31,  11'd30,
    11'd30,   11'd29,   11'd28,  11'd27,  11'd27,  11'd26,  11'd26,  11'd25,
    11'd25,   11'd24,   11'd24,  11'd23,  11'd23,  11'd22,  11'd22,  11'd21,
    11'd21,   11'd21,   11'd20,  11'd20,  11'd20,  11'd20,  11'd20,  11'd20
  };

  function automatic logic [DOT_W-1:0] dot_len(input logic [5:0] spd);
    dot_len = DOT_TAB[spd];
  endfunction

endpackage

`default_nettype wire

[rtl/icwk_len.sv]
// ----------------------------------------------------------------------------
// icwk_len
// Holds speed and weight and recomputes dot and dash lengths after a write.
// ----------------------------------------------------------------------------
`default_nettype none

module icwk_len (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [icwk_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [icwk_pkg::CFG_DW-1:0]   cfg_wdata,
  output logic      [icwk_pkg::DOT_W-1:0]    dot_ticks,
  output logic      [icwk_pkg::DASH_W-1:0]   dash_ticks,
  output logic                               busy
);
  import icwk_pkg::*;

  // x/50 == (x * RECIP_50) >> RECIP_SH for x below 2^19
  localparam logic [19:0] RECIP_50 = 20'd671089;
  localparam int          RECIP_SH = 25;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_TAB  = 4'b0010,
    L_MUL  = 4'b0100,
    L_DIV  = 4'b1000
  } len_state_t;

  len_state_t        phase_r, phase_nxt;
  logic [5:0]        spd_r;
  logic [6:0]        wgt_r;
  logic [DOT_W-1:0]  dot_r;
  logic [DASH_W-1:0] dash_r;
  logic [8:0]        w3_r;
  logic [18:0]       prod_r;
  logic [6:0]        w_sat;
  logic [19:0]       prod_full;
  logic [38:0]       quot_full;
  logic              len_wr;

  assign len_wr = cfg_we && (cfg_addr == REG_SPEED || cfg_addr == REG_WEIGHT);

  always_comb begin
    if (wgt_r < 7'd10) begin
      w_sat = 7'd10;
    end else if (wgt_r > 7'd90) begin
      w_sat = 7'd90;
    end else begin
      w_sat = wgt_r;
    end
  end

  assign prod_full = 20'(dot_r) * 20'(w3_r);
  assign quot_full = 39'(prod_r) * 39'(RECIP_50);

  always_comb begin
    case (phase_r)
      L_IDLE:  phase_nxt = L_IDLE;
      L_TAB:   phase_nxt = L_MUL;
      L_MUL:   phase_nxt = L_DIV;
      L_DIV:   phase_nxt = L_IDLE;
      default: phase_nxt = L_IDLE;
    endcase
    if (len_wr) begin
      phase_nxt = L_TAB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= L_IDLE;
      spd_r   <= SPEED_RST;
      wgt_r   <= WEIGHT_RST;
      dot_r   <= DOT_RST;
      dash_r  <= DASH_RST;
    end else begin
      phase_r <= phase_nxt;
      if (cfg_we && cfg_addr == REG_SPEED) begin
        spd_r <= cfg_wdata[5:0];
      end
      if (cfg_we && cfg_addr == REG_WEIGHT) begin
        wgt_r <= cfg_wdata[6:0];
      end
      if (phase_r == L_TAB) begin
        dot_r <= dot_len(spd_r);
      end
      if (phase_r == L_DIV) begin
        dash_r <= quot_full[RECIP_SH +: DASH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == L_TAB) begin
      w3_r <= ({2'b00, w_sat} << 1) + {2'b00, w_sat};
    end
    if (phase_r == L_MUL) begin
      prod_r <= prod_full[18:0];
    end
  end

  assign dot_ticks  = dot_r;
  assign dash_ticks = dash_r;
  assign busy       = (phase_r != L_IDLE);

endmodule

`default_nettype wire

[rtl/icwk_core.sv]
// ----------------------------------------------------------------------------
// icwk_core
// Element sequencer: keyer state, tick counter, memories, held flags and PTT.
// ----------------------------------------------------------------------------
`default_nettype none

module icwk_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire icwk_pkg::item_t               item,
  input  wire icwk_pkg::cfg_t                cfg,
  input  wire logic [icwk_pkg::DOT_W-1:0]    dot_ticks,
  input  wire logic [icwk_pkg::DASH_W-1:0]   dash_ticks,
  output logic                               key_out,
  output logic                               ptt
);
  import icwk_pkg::*;

  typedef enum logic [7:0] {
    S_EXIT     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_STRAIGHT = 8'b0000_0100,
    S_DOT      = 8'b0000_1000,
    S_DOTDLY   = 8'b0001_0000,
    S_DASH     = 8'b0010_0000,
    S_DASHDLY  = 8'b0100_0000,
    S_SPACE    = 8'b1000_0000
  } key_state_t;

  key_state_t        st_r, st_nxt;
  logic [TICK_W-1:0] tc_r, tc_nxt;
  logic [HANG_W-1:0] vox_r, vox_nxt;
  logic              dot_mem_r, dot_mem_nxt;
  logic              dash_mem_r, dash_mem_nxt;
  logic              dot_held_r, dot_held_nxt;
  logic              dash_held_r, dash_held_nxt;
  logic              ptt_r, ptt_nxt;
  logic              key_nxt;
  logic              do_check;
  logic              kdot, kdash;
  logic              iambic_a;
  logic [TICK_W-1:0] dot_ext, space_len;

  assign kdot      = cfg.keys_reversed ? item.right_level : item.left_level;
  assign kdash     = cfg.keys_reversed ? item.left_level  : item.right_level;
  assign iambic_a  = (cfg.keyer_mode == MODE_IAMBIC_A);
  assign dot_ext   = {2'b00, dot_ticks};
  assign space_len = {1'b0, dot_ticks, 1'b0};

  always_comb begin
    st_nxt        = st_r;
    tc_nxt        = tc_r;
    vox_nxt       = vox_r;
    dot_mem_nxt   = dot_mem_r;
    dash_mem_nxt  = dash_mem_r;
    dot_held_nxt  = dot_held_r;
    dash_held_nxt = dash_held_r;
    ptt_nxt       = ptt_r;
    key_nxt       = 1'b0;
    do_check      = 1'b0;

    // any active element or gap restarts a running hang time
    if (st_r != S_EXIT && st_r != S_CHECK && vox_r != '0) begin
      vox_nxt = cfg.hang_ticks;
    end

    case (st_r)
      S_EXIT: begin
        if (vox_r != '0) begin
          vox_nxt = vox_r - 1'b1;
          if (vox_nxt != '0) begin
            st_nxt = S_CHECK;
          end
        end else if ((item.left_hit || item.right_hit) &&
                     (item.left_level || item.right_level)) begin
          if (!item.tx_on && cfg.breakin) begin
            ptt_nxt = 1'b1;
            vox_nxt = cfg.hang_ticks;
          end
          do_check = 1'b1;
        end
      end
      S_CHECK: begin
        do_check = 1'b1;
      end
      S_STRAIGHT: begin
        if (kdash) begin
          key_nxt = 1'b1;
        end else begin
          vox_nxt = cfg.hang_ticks;
          if (kdot) begin
            st_nxt = S_DOT;
            tc_nxt = '0;
          end else begin
            st_nxt = S_EXIT;
          end
        end
      end
      S_DOT: begin
        if (tc_r == '0) begin
          dash_mem_nxt  = 1'b0;
          dash_held_nxt = kdash;
        end
        if (tc_r < dot_ext) begin
          key_nxt = 1'b1;
          tc_nxt  = tc_r + 1'b1;
        end else begin
          st_nxt = S_DOTDLY;
          tc_nxt = '0;
        end
      end
      S_DASH: begin
        if (tc_r == '0) begin
          dot_mem_nxt  = 1'b0;
          dot_held_nxt = kdot;
        end
        if (tc_r < dash_ticks) begin
          key_nxt = 1'b1;
          tc_nxt  = tc_r + 1'b1;
        end else begin
          st_nxt = S_DASHDLY;
          tc_nxt = '0;
        end
      end
      S_DOTDLY: begin
        tc_nxt = tc_r + 1'b1;
        if (tc_nxt > dot_ext) begin
          tc_nxt = '0;
          if (cfg.keyer_mode == MODE_STRAIGHT) begin
            if (kdot) begin
              st_nxt = S_DOT;
            end else begin
              st_nxt = S_EXIT;
              tc_nxt = tc_r + 1'b1;
            end
          end else begin
            if (iambic_a && !kdot && !kdash) begin
              dash_held_nxt = 1'b0;
            end
            if (dash_mem_r || kdash || dash_held_nxt) begin
              st_nxt = S_DASH;
            end else if (kdot) begin
              st_nxt = S_DOT;
            end else if (cfg.letter_spacing) begin
              dot_mem_nxt  = 1'b0;
              dash_mem_nxt = 1'b0;
              st_nxt       = S_SPACE;
            end else begin
              st_nxt = S_EXIT;
              tc_nxt = tc_r + 1'b1;
            end
          end
        end
      end
      S_DASHDLY: begin
        tc_nxt = tc_r + 1'b1;
        if (tc_nxt > dot_ext) begin
          tc_nxt = '0;
          if (iambic_a && !kdot && !kdash) begin
            dot_held_nxt = 1'b0;
          end
          if (dot_mem_r || kdot || dot_held_nxt) begin
            st_nxt = S_DOT;
          end else if (kdash) begin
            st_nxt = S_DASH;
          end else if (cfg.letter_spacing) begin
            dot_mem_nxt  = 1'b0;
            dash_mem_nxt = 1'b0;
            st_nxt       = S_SPACE;
          end else begin
            st_nxt = S_EXIT;
            tc_nxt = tc_r + 1'b1;
          end
        end
      end
      S_SPACE: begin
        tc_nxt = tc_r + 1'b1;
        if (tc_nxt > space_len) begin
          if (dot_mem_r) begin
            st_nxt = S_DOT;
            tc_nxt = '0;
          end else if (dash_mem_r) begin
            st_nxt = S_DASH;
            tc_nxt = '0;
          end else begin
            st_nxt = S_EXIT;
          end
        end
      end
      default: begin
        st_nxt = S_EXIT;
      end
    endcase

    // decide the next element from the paddles
    if (do_check) begin
      st_nxt = S_EXIT;
      if (vox_nxt > 12'd1) begin
        vox_nxt = vox_nxt - 1'b1;
      end
      if (cfg.keyer_mode == MODE_STRAIGHT) begin
        if (kdash) begin
          st_nxt  = S_STRAIGHT;
          key_nxt = 1'b1;
        end else if (kdot) begin
          st_nxt = S_DOT;
          tc_nxt = '0;
        end
      end else begin
        if (kdash) begin
          st_nxt = S_DASH;
          tc_nxt = '0;
        end
        if (kdot) begin
          st_nxt = S_DOT;
          tc_nxt = '0;
        end
      end
    end

    // press events land after the update so they survive an element start
    if (item.left_hit) begin
      if (cfg.keys_reversed) begin
        dash_mem_nxt = 1'b1;
      end else begin
        dot_mem_nxt = 1'b1;
      end
    end
    if (item.right_hit) begin
      if (cfg.keys_reversed) begin
        dot_mem_nxt = 1'b1;
      end else begin
        dash_mem_nxt = 1'b1;
      end
    end

    if (st_nxt == S_EXIT && vox_nxt == '0) begin
      ptt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_EXIT;
      tc_r        <= '0;
      vox_r       <= '0;
      dot_mem_r   <= 1'b0;
      dash_mem_r  <= 1'b0;
      dot_held_r  <= 1'b0;
      dash_held_r <= 1'b0;
      ptt_r       <= 1'b0;
    end else if (step) begin
      st_r        <= st_nxt;
      tc_r        <= tc_nxt;
      vox_r       <= vox_nxt;
      dot_mem_r   <= dot_mem_nxt;
      dash_mem_r  <= dash_mem_nxt;
      dot_held_r  <= dot_held_nxt;
      dash_held_r <= dash_held_nxt;
      ptt_r       <= ptt_nxt;
    end
  end

  assign key_out = key_nxt;
  assign ptt     = ptt_nxt;

  // PTT never survives an idle keyer with the hang time run out
  a_ptt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXIT && vox_r == '0) |-> !ptt_r)
    else $error("ptt held while keyer idle");

  // a keyed tick leaves the keyer in a keying state
  a_key_state: assert property (@(posedge clk) disable iff (!rst_n)
    (step && key_nxt) |=> (st_r == S_STRAIGHT || st_r == S_DOT || st_r == S_DASH))
    else $error("key out without keying state");

endmodule

`default_nettype wire

[rtl/iambic_cw_keyer.sv]
// ----------------------------------------------------------------------------
// iambic_cw_keyer
// Iambic and straight Morse keyer advanced by one tick item per millisecond.
// ----------------------------------------------------------------------------
// A result is registered when its tick item steps out of the input register.
// Throughput: one item per cycle while out_tready is high and u_len is idle;
//   the input and result registers let a new item enter while a finished
//   result waits to be taken. A write to speed or weight holds off input
//   while the dot table lookup and the two length multiplies run.
// Reset (synchronous, rst_n low): control registers take defaults, keyer idle.
`default_nettype none

module iambic_cw_keyer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [0] left_level [1] right_level [2] left_hit [3] right_hit [4] tx_on
  input  wire logic [7:0]                    in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] key_out [1] ptt
  output logic      [7:0]                    out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [icwk_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [icwk_pkg::CFG_DW-1:0]   cfg_wdata
);
  import icwk_pkg::*;

  cfg_t              cfg_r;
  item_t             item_r;
  logic              in_v_r;
  logic              out_v_r;
  logic              key_r, ptt_r;
  logic              advance;
  logic              step;
  logic              len_busy;
  logic              key_nxt, ptt_nxt;
  logic [DOT_W-1:0]  dot_ticks;
  logic [DASH_W-1:0] dash_ticks;

  assign advance   = !out_v_r || out_tready;
  assign step      = advance && in_v_r;
  assign in_tready = !len_busy && (!in_v_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keyer_mode     <= MODE_RST;
      cfg_r.keys_reversed  <= 1'b0;
      cfg_r.letter_spacing <= 1'b0;
      cfg_r.hang_ticks     <= HANG_RST;
      cfg_r.breakin        <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:     cfg_r.keyer_mode     <= cfg_wdata[1:0];
        REG_REVERSED: cfg_r.keys_reversed  <= cfg_wdata[0];
        REG_SPACING:  cfg_r.letter_spacing <= cfg_wdata[0];
        REG_HANG:     cfg_r.hang_ticks     <= cfg_wdata[HANG_W-1:0];
        REG_BREAKIN:  cfg_r.breakin        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input and result stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[4:0]);
    end
    if (step) begin
      key_r <= key_nxt;
      ptt_r <= ptt_nxt;
    end
  end

  icwk_len u_len (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .dot_ticks  (dot_ticks),
    .dash_ticks (dash_ticks),
    .busy       (len_busy)
  );

  icwk_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (item_r),
    .cfg        (cfg_r),
    .dot_ticks  (dot_ticks),
    .dash_ticks (dash_ticks),
    .key_out    (key_nxt),
    .ptt        (ptt_nxt)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b000000, ptt_r, key_r};

  // no item enters while the lengths are being rebuilt
  a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    len_busy |-> !in_tready)
    else $error("item accepted during length update");

  // a waiting item stays put while the result stage is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> in_v_r)
    else $error("item dropped in input stage");

endmodule

`default_nettype wire
